FILE: rtl/core/twms_pkg.sv
// ----------------------------------------------------------------------------
// twms_pkg
// Shared types and constants for the torus window max-sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package twms_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SIZE      = 64;
    localparam int DEF_ELEMENT_WIDTH = 16;

    // Fixed payload widths
    localparam int ELEM_IN_W = 16;
    localparam int OUT_W     = 22;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Configuration port
    localparam int CFG_W    = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [CFG_W-1:0] SIZE_RESET   = 7'd8;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

    // Register index, taken from paddr[2]
    localparam logic CFG_MATRIX_SIZE   = 1'b0;
    localparam logic CFG_WINDOW_LENGTH = 1'b1;

    // Line families, scanned in this order
    typedef enum logic [1:0] {
        DIR_COL  = 2'd0,
        DIR_ROW  = 2'd1,
        DIR_DOWN = 2'd2,
        DIR_UP   = 2'd3
    } dir_t;

    // Control tag that travels with each memory read of the scan
    typedef struct packed {
        logic valid;   // a read is in flight
        logic clear;   // first element of a line: start a fresh sum
        logic sub;     // element leaves the window
        logic cmp;     // window complete after this update
    } scan_tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/twms_elem_if.sv
// ----------------------------------------------------------------------------
// twms_elem_if
// Valid/ready channel carrying one matrix element per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface twms_elem_if import twms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ELEM_IN_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/twms_result_if.sv
// ----------------------------------------------------------------------------
// twms_result_if
// Valid/ready channel carrying one window maximum per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface twms_result_if import twms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] best_sum;

    modport source (output valid, output best_sum, input ready);
    modport sink   (input valid, input best_sum, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/torus_window_max_sum.sv
// ----------------------------------------------------------------------------
// torus_window_max_sum
// Loads an n x n matrix row by row into a single-port store, then scans it
// as a torus for the largest sum of k consecutive elements along columns,
// rows and both diagonal families, and emits that maximum.
// ----------------------------------------------------------------------------
//  Channel          Dir   Handshake          Payload
//  element_stream   in    valid/ready        element  [15:0]
//  result_stream    out   valid/ready        best_sum [21:0]
//  APB (psel...)    in    setup + access     matrix_size @0x0, window_length @0x4
//
//  Loading accepts one element per cycle. The element that completes the
//  matrix starts a scan: 4*n*(k + 2*(n-1)) store reads, one per cycle on the
//  single memory port, followed by a drain of the read/accumulate pipeline.
//  No element is taken during the scan. The result sits in an output
//  register; the next matrix loads while it waits, but a finished scan holds
//  until that register is free. Reset clears control state and the running
//  sum and maximum, not the store or the output data register.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_window_max_sum import twms_pkg::*; #(
    parameter int MAX_SIZE      = DEF_MAX_SIZE,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    twms_elem_if.sink               element_stream,
    twms_result_if.source           result_stream,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int SIZE_W  = $clog2(MAX_SIZE + 1);
    localparam int POS_W   = $clog2(MAX_SIZE);
    localparam int ADDR_W  = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int NN_W    = 2 * SIZE_W;
    localparam int SUM_W   = ELEMENT_WIDTH + SIZE_W;
    localparam int CMP_W   = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int CLAMP_W = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
    localparam int IN_BITS = (ELEMENT_WIDTH < ELEM_IN_W) ? ELEMENT_WIDTH : ELEM_IN_W;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } ctl_state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] size_reg;
    logic [CFG_W-1:0] window_reg;
    logic             cfg_write;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SIZE_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == CFG_MATRIX_SIZE)
                size_reg <= pwdata[CFG_W-1:0];
            else
                window_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_MATRIX_SIZE) ? PDATA_W'(size_reg)
                                                  : PDATA_W'(window_reg);

    // Effective size n in [1, MAX_SIZE] and window k in [1, n]
    logic [CLAMP_W-1:0] size_ext;
    logic [CLAMP_W-1:0] window_ext;
    logic [SIZE_W-1:0]  n_eff;
    logic [SIZE_W-1:0]  k_eff;

    always_comb
    begin
        size_ext   = CLAMP_W'(size_reg);
        window_ext = CLAMP_W'(window_reg);
        if (size_ext == '0)
            n_eff = SIZE_W'(1);
        else if (size_ext > CLAMP_W'(MAX_SIZE))
            n_eff = SIZE_W'(MAX_SIZE);
        else
            n_eff = SIZE_W'(size_ext);

        if (window_ext == '0)
            k_eff = SIZE_W'(1);
        else if (window_ext > CLAMP_W'(n_eff))
            k_eff = n_eff;
        else
            k_eff = SIZE_W'(window_ext);
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    ctl_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] load_count_reg, load_count_next;
    logic [NN_W-1:0]   nn;
    logic              in_fire;
    logic              load_done;
    logic              scan_start;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  best_sum_reg, best_sum_next;

    // Scan pipeline
    logic              seq_busy;
    scan_tag_t         seq_tag;
    logic [POS_W-1:0]  seq_row;
    logic [POS_W-1:0]  seq_col;
    scan_tag_t         s2_tag_reg;
    logic              cmp_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  best_reg;
    logic              pipe_empty;
    logic [CMP_W-1:0]  best_ext;
    logic [OUT_W-1:0]  best_sat;

    assign nn        = NN_W'(n_eff) * NN_W'(n_eff);
    assign in_fire   = element_stream.valid && element_stream.ready;
    assign load_done = (NN_W'(load_count_reg) + NN_W'(1)) >= nn;
    assign scan_start = in_fire && load_done;

    assign element_stream.ready = (state_reg == ST_LOAD);

    assign pipe_empty = !seq_tag.valid && !s2_tag_reg.valid && !cmp_reg;
    assign best_ext   = CMP_W'(best_reg);
    assign best_sat   = (best_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(best_ext);

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        out_valid_next  = out_valid_reg;
        best_sum_next   = best_sum_reg;

        if (result_stream.valid && result_stream.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (load_done)
                    begin
                        load_count_next = '0;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + ADDR_W'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (!seq_busy)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last compare done and the previous result has been taken
                if (pipe_empty && !out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    best_sum_next  = best_sat;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_sum_reg <= best_sum_next;
    end

    assign result_stream.valid    = out_valid_reg;
    assign result_stream.best_sum = best_sum_reg;

    // ------------------------------------------------------------------
    // Scan sequencer: one coordinate per cycle, registered
    // ------------------------------------------------------------------
    twms_scan_seq #(
        .MAX_SIZE (MAX_SIZE)
    ) u_scan_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .n     (n_eff),
        .k     (k_eff),
        .busy  (seq_busy),
        .tag   (seq_tag),
        .row   (seq_row),
        .col   (seq_col)
    );

    // ------------------------------------------------------------------
    // Element store: single port, write during load, read during scan
    // ------------------------------------------------------------------
    logic [ELEMENT_WIDTH-1:0] store [DEPTH];
    logic [ELEMENT_WIDTH-1:0] wr_data;
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]        scan_addr;
    logic [ADDR_W-1:0]        mem_addr;

    assign wr_data   = ELEMENT_WIDTH'(element_stream.element[IN_BITS-1:0]);
    assign scan_addr = ADDR_W'(seq_row) * ADDR_W'(n_eff) + ADDR_W'(seq_col);
    assign mem_addr  = (state_reg == ST_LOAD) ? load_count_reg : scan_addr;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            store[mem_addr] <= wr_data;
        else
            rd_data_reg <= store[mem_addr];
    end

    // ------------------------------------------------------------------
    // Running sum and maximum
    // Sum is updated in the cycle after the read; the compare against the best
    // uses the completed sum in the cycle after that, so it sees the value
    // before the next slide lands.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s2_tag_reg.sub)
            sum_next = sum_reg - SUM_W'(rd_data_reg);
        else if (s2_tag_reg.clear)
            sum_next = SUM_W'(rd_data_reg);
        else
            sum_next = sum_reg + SUM_W'(rd_data_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
            cmp_reg    <= 1'b0;
            sum_reg    <= '0;
            best_reg   <= '0;
        end
        else
        begin
            s2_tag_reg <= seq_tag;
            cmp_reg    <= s2_tag_reg.valid && s2_tag_reg.cmp;
            if (s2_tag_reg.valid)
                sum_reg <= sum_next;
            if (scan_start)
                best_reg <= '0;
            else if (cmp_reg && (sum_reg > best_reg))
                best_reg <= sum_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The memory port belongs to the loader while loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !seq_tag.valid)
        else $error("scan read issued during load");

    // Every completed window is folded into the running maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_reg |=> (best_reg >= $past(sum_reg)))
        else $error("window sum lost from maximum");

    // A result only appears at the end of a drained scan
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DRAIN))
        else $error("result raised outside scan end");

endmodule

`default_nettype wire

FILE: rtl/core/twms_scan_seq.sv
// ----------------------------------------------------------------------------
// twms_scan_seq
// Scan sequencer: walks all four line families and issues one element
// coordinate per cycle with its accumulate tag, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module twms_scan_seq import twms_pkg::*; #(
    parameter int MAX_SIZE = DEF_MAX_SIZE,
    localparam int SIZE_W = $clog2(MAX_SIZE + 1),
    localparam int POS_W  = $clog2(MAX_SIZE)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SIZE_W-1:0] n,
    input  wire logic [SIZE_W-1:0] k,
    output logic                   busy,
    output scan_tag_t              tag,
    output logic [POS_W-1:0]       row,
    output logic [POS_W-1:0]       col
);

    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_INIT = 4'b0010,
        SQ_SUB  = 4'b0100,
        SQ_ADD  = 4'b1000
    } seq_state_t;

    seq_state_t        seq_reg, seq_next;
    dir_t              dir_reg, dir_next;
    logic [POS_W-1:0]  line_reg, line_next;
    logic [POS_W-1:0]  lead_reg, lead_next;   // position entering the window
    logic [POS_W-1:0]  tail_reg, tail_next;   // position leaving the window
    logic [POS_W-1:0]  cnt_reg, cnt_next;     // init count, then slide step
    scan_tag_t         tag_reg, tag_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;

    logic [POS_W-1:0]  pos;
    logic [POS_W:0]    diag_sum;
    logic [POS_W-1:0]  diag_col;
    logic [POS_W-1:0]  flip_row;
    logic [POS_W-1:0]  lead_inc;
    logic              last_init;
    logic              last_step;
    logic              last_line;
    logic              end_line;

    // Coordinates of the element at pos along the current line
    always_comb
    begin
        pos      = (seq_reg == SQ_SUB) ? tail_reg : lead_reg;
        diag_sum = {1'b0, line_reg} + {1'b0, pos};
        diag_col = (diag_sum >= (POS_W + 1)'(n)) ? POS_W'(diag_sum - (POS_W + 1)'(n))
                                                   : POS_W'(diag_sum);
        flip_row = POS_W'(n - SIZE_W'(1) - SIZE_W'(pos));
        case (dir_reg)
            DIR_COL:
            begin
                row_next = pos;
                col_next = line_reg;
            end
            DIR_ROW:
            begin
                row_next = line_reg;
                col_next = pos;
            end
            DIR_DOWN:
            begin
                row_next = pos;
                col_next = diag_col;
            end
            default:
            begin
                row_next = flip_row;
                col_next = diag_col;
            end
        endcase
    end

    assign lead_inc  = (SIZE_W'(lead_reg) == n - SIZE_W'(1)) ? '0 : lead_reg + POS_W'(1);
    assign last_init = (SIZE_W'(cnt_reg) == k - SIZE_W'(1));
    assign last_step = (SIZE_W'(cnt_reg) == n - SIZE_W'(1));
    assign last_line = (SIZE_W'(line_reg) == n - SIZE_W'(1));

    always_comb
    begin
        seq_next  = seq_reg;
        dir_next  = dir_reg;
        line_next = line_reg;
        lead_next = lead_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        tag_next  = '0;
        end_line  = 1'b0;

        case (seq_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    seq_next  = SQ_INIT;
                    dir_next  = DIR_COL;
                    line_next = '0;
                    lead_next = '0;
                    cnt_next  = '0;
                end
            end
            SQ_INIT:
            begin
                tag_next.valid = 1'b1;
                tag_next.clear = (cnt_reg == '0);
                tag_next.cmp   = last_init;
                lead_next      = lead_inc;
                if (last_init)
                begin
                    cnt_next  = POS_W'(1);
                    tail_next = '0;
                    if (n == SIZE_W'(1))
                        end_line = 1'b1;
                    else
                        seq_next = SQ_SUB;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            SQ_SUB:
            begin
                tag_next.valid = 1'b1;
                tag_next.sub   = 1'b1;
                tail_next      = tail_reg + POS_W'(1);
                seq_next       = SQ_ADD;
            end
            SQ_ADD:
            begin
                tag_next.valid = 1'b1;
                tag_next.cmp   = 1'b1;
                lead_next      = lead_inc;
                if (last_step)
                begin
                    end_line = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                    seq_next = SQ_SUB;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase

        if (end_line)
        begin
            lead_next = '0;
            cnt_next  = '0;
            if (last_line)
            begin
                line_next = '0;
                if (dir_reg == DIR_UP)
                begin
                    seq_next = SQ_IDLE;
                end
                else
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                    seq_next = SQ_INIT;
                end
            end
            else
            begin
                line_next = line_reg + POS_W'(1);
                seq_next  = SQ_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= SQ_IDLE;
            dir_reg  <= DIR_COL;
            line_reg <= '0;
            lead_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            tag_reg  <= '0;
        end
        else
        begin
            seq_reg  <= seq_next;
            dir_reg  <= dir_next;
            line_reg <= line_next;
            lead_reg <= lead_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            tag_reg  <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
    end

    assign busy = (seq_reg != SQ_IDLE);
    assign tag  = tag_reg;
    assign row  = row_reg;
    assign col  = col_reg;

endmodule

`default_nettype wire

FILE: tb/tb_torus_window_max_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_torus_window_max_sum
// Self-checking bench for the torus window max-sum block: streams square
// matrices through the element channel, mirrors the store and the registers
// to predict each cyclic window maximum, and checks every result transaction.
// ----------------------------------------------------------------------------

module tb_torus_window_max_sum;

    import twms_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_SIZE * DEF_MAX_SIZE;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int TARGET_PHASE  = 120;      // elements per random phase, roughly
    localparam int SETTLE_CYCLES = 16;       // scan pipeline drain plus margin
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int MAX_REPORTS   = 40;
    localparam bit [ELEM_IN_W-1:0] ELEM_MASK =
        (DEF_ELEMENT_WIDTH >= ELEM_IN_W) ? {ELEM_IN_W{1'b1}}
                                         : ELEM_IN_W'((1 << DEF_ELEMENT_WIDTH) - 1);

    // Idle modes, one per random phase in rotation
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    twms_elem_if   elem_if ();
    twms_result_if res_if ();

    // Bench-side drivers of the channel inputs; known from time zero
    logic                 elem_valid = 1'b0;
    logic [ELEM_IN_W-1:0] elem_data  = '0;
    logic                 res_ready  = 1'b0;

    assign elem_if.valid   = elem_valid;
    assign elem_if.element = elem_data;
    assign res_if.ready    = res_ready;

    // APB, written only by the sequencer
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    torus_window_max_sum u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .element_stream (elem_if),
        .result_stream  (res_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    bit [ELEM_IN_W-1:0] pending_elements [$];   // not yet accepted by the block
    bit [OUT_W-1:0]     expected_best    [$];   // predicted maxima, oldest first

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    logic elem_fired   = 1'b0;                  // element transaction at last edge

    // Mirror of the block's store, load pointer and registers
    bit [ELEM_IN_W-1:0] elem_mirror [STORE_DEPTH];
    int unsigned        mirror_count = 0;
    bit [CFG_W-1:0]     size_reg     = SIZE_RESET;
    bit [CFG_W-1:0]     window_reg   = WINDOW_RESET;

    bit [OUT_W-1:0]     got_best;
    bit [OUT_W-1:0]     want_best;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Register value 0 reads as 1; anything past the store side reads as
    // the full side length.
    function automatic int unsigned clamp_size(bit [CFG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > DEF_MAX_SIZE)
            return DEF_MAX_SIZE;
        return raw;
    endfunction

    // Window is clamped to [1, n]
    function automatic int unsigned clamp_window(bit [CFG_W-1:0] raw, int unsigned n);
        if (raw == 0)
            return 1;
        if (raw > n)
            return n;
        return raw;
    endfunction

    // Element p along line i of family d, all indices modulo n
    function automatic longint unsigned torus_elem(dir_t d, int unsigned i,
                                                   int unsigned p, int unsigned n);
        int unsigned r;
        int unsigned c;
        case (d)
            DIR_COL:
            begin
                r = p;
                c = i;
            end
            DIR_ROW:
            begin
                r = i;
                c = p;
            end
            DIR_DOWN:
            begin
                r = p;
                c = (i + p) % n;
            end
            default:
            begin
                r = n - 1 - p;
                c = (i + p) % n;
            end
        endcase
        return elem_mirror[(r * n + c) % STORE_DEPTH];
    endfunction

    // Largest sliding window sum over all four line families
    function automatic bit [OUT_W-1:0] best_window_sum(int unsigned n, int unsigned k);
        longint unsigned run;
        longint unsigned best;
        dir_t            d;
        best = 0;
        for (int di = 0; di < 4; di++)
        begin
            d = dir_t'(di);
            for (int unsigned i = 0; i < n; i++)
            begin
                run = 0;
                for (int unsigned j = 0; j < k; j++)
                    run += torus_elem(d, i, j, n);
                if (run > best)
                    best = run;
                for (int unsigned s = 1; s < n; s++)
                begin
                    run -= torus_elem(d, i, s - 1, n);
                    run += torus_elem(d, i, (s + k - 1) % n, n);
                    if (run > best)
                        best = run;
                end
            end
        end
        return (best > OUT_MAX) ? OUT_MAX : best[OUT_W-1:0];
    endfunction

    // One accepted element: store it, and predict a result once the matrix
    // is full. A shrunken size with more already loaded completes at once.
    function automatic void absorb_element(bit [ELEM_IN_W-1:0] value);
        int unsigned n;
        int unsigned k;
        n = clamp_size(size_reg);
        k = clamp_window(window_reg, n);
        elem_mirror[mirror_count % STORE_DEPTH] = value & ELEM_MASK;
        mirror_count++;
        if (mirror_count >= n * n)
        begin
            mirror_count = 0;
            expected_best.push_back(best_window_sum(n, k));
        end
    endfunction

    // ------------------------------------------------------------------
    // Element driver: changes at the falling edge, holds valid until the
    // transaction is taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            elem_valid <= 1'b0;
            elem_data  <= '0;
        end
        else if (!elem_valid || elem_fired)
        begin
            if (pending_elements.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                elem_valid <= 1'b1;
                elem_data  <= pending_elements[0];
            end
            else
            begin
                elem_valid <= 1'b0;
            end
        end
    end

    // Element monitor: the prediction follows the accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            elem_fired <= 1'b0;
        end
        else
        begin
            elem_fired <= elem_if.valid && elem_if.ready;
            if (elem_if.valid && elem_if.ready)
            begin
                absorb_element(elem_if.element);
                void'(pending_elements.pop_front());
            end
        end
    end

    // Result receiver: random back-pressure per the current mode
    always @(negedge clk)
    begin
        res_ready <= rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Result monitor: compare against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got_best = res_if.best_sum;
            if (expected_best.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected best_sum transaction, expected none, actual %0d",
                             $time, got_best);
                error_count++;
            end
            else
            begin
                want_best = expected_best.pop_front();
                if (got_best !== want_best)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: best_sum mismatch, expected %0d, actual %0d",
                                 $time, want_best, got_best);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d elements pending, %0d results outstanding",
                     $time, pending_elements.size(), expected_best.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    // APB write: setup, access, register taken when pready is seen
    task automatic reg_write(input logic idx, input bit [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == CFG_MATRIX_SIZE)
            size_reg = value;
        else
            window_reg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block idle: everything accepted, every result back, scan drained
    task automatic wait_idle();
        while (pending_elements.size() != 0 || expected_best.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                src_idle_pct   = 71;
                sink_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 71;
            end
            default:
            begin
                src_idle_pct   = 18;
                sink_stall_pct = 18;
            end
        endcase
    endtask

    // Biased toward the extremes so that window sums tie
    function automatic bit [ELEM_IN_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ELEM_IN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n;
        int unsigned size_pick;
        int unsigned win_pick;
        bit [CFG_W-1:0] size_raw;
        bit [CFG_W-1:0] win_raw;
        int unsigned matrices;
        int          queued;
        int          phase;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // -- Directed --------------------------------------------------
        // Zero registers act as 1x1 with window 1: each element is a result.
        reg_write(CFG_MATRIX_SIZE, 7'd0);
        reg_write(CFG_WINDOW_LENGTH, 7'd0);
        pending_elements.push_back(16'h0000);
        pending_elements.push_back(16'hFFFF);
        wait_idle();

        // 2x2 of full-scale elements, full window
        reg_write(CFG_MATRIX_SIZE, 7'd2);
        reg_write(CFG_WINDOW_LENGTH, 7'd2);
        repeat (4) pending_elements.push_back(16'hFFFF);
        wait_idle();

        // Oversized window clamps to 3; then shrink the matrix mid-load
        // below what is already loaded, so the next element completes it.
        reg_write(CFG_MATRIX_SIZE, 7'd3);
        reg_write(CFG_WINDOW_LENGTH, 7'd127);
        pending_elements.push_back(16'hAAAA);
        pending_elements.push_back(16'h5555);
        pending_elements.push_back(16'h0001);
        pending_elements.push_back(16'h8000);
        pending_elements.push_back(16'hFFFF);
        wait_idle();
        reg_write(CFG_MATRIX_SIZE, 7'd2);
        pending_elements.push_back(16'h1234);
        wait_idle();

        // Grow the matrix mid-load: 2 loaded at n=2, finish as a 3x3
        pending_elements.push_back(16'h00FF);
        pending_elements.push_back(16'hFF00);
        wait_idle();
        reg_write(CFG_MATRIX_SIZE, 7'd3);
        pending_elements.push_back(16'h0F0F);
        pending_elements.push_back(16'hF0F0);
        pending_elements.push_back(16'h7FFF);
        pending_elements.push_back(16'h0000);
        pending_elements.push_back(16'hFFFE);
        pending_elements.push_back(16'h3C3C);
        pending_elements.push_back(16'hC3C3);
        wait_idle();

        // -- Random phases ---------------------------------------------
        // Mostly whole matrices with random content at small sizes; some
        // phases end mid-matrix so the next size change lands mid-load.
        queued = 0;
        phase  = 0;
        while (queued < RANDOM_ITEMS)
        begin
            set_idle_mode(idle_mode_t'(phase % 4));

            size_pick = $urandom_range(0, 99);
            if (size_pick < 8)
                size_raw = 7'd0;
            else if (size_pick < 20)
                size_raw = 7'd1;
            else if (size_pick < 28)
                size_raw = CFG_W'($urandom_range(9, 16));
            else
                size_raw = CFG_W'($urandom_range(2, 8));
            n = clamp_size(size_raw);

            win_pick = $urandom_range(0, 99);
            if (win_pick < 10)
                win_raw = 7'd0;
            else if (win_pick < 20)
                win_raw = 7'd127;
            else if (win_pick < 30)
                win_raw = CFG_W'($urandom_range(n, DEF_MAX_SIZE));
            else
                win_raw = CFG_W'($urandom_range(1, n));

            if ($urandom_range(0, 1))
            begin
                reg_write(CFG_MATRIX_SIZE, size_raw);
                reg_write(CFG_WINDOW_LENGTH, win_raw);
            end
            else
            begin
                reg_write(CFG_WINDOW_LENGTH, win_raw);
                reg_write(CFG_MATRIX_SIZE, size_raw);
            end

            matrices = (TARGET_PHASE / (n * n) > 0) ? TARGET_PHASE / (n * n) : 1;
            for (int unsigned m = 0; m < matrices; m++)
            begin
                for (int unsigned e = 0; e < n * n; e++)
                begin
                    pending_elements.push_back(pick_element());
                    queued++;
                end
                // hold the sender off until every result is back
                if (phase == 2 && m == 0)
                    wait_idle();
            end

            // broken sequence: leave a partial matrix behind
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(0, n * n - 1))
                begin
                    pending_elements.push_back(pick_element());
                    queued++;
                end
            end

            wait_idle();
            phase++;
        end

        // -- Top-end clamps --------------------------------------------
        // Close any partial matrix from the last phase at its own size.
        set_idle_mode(IDLE_BOTH);
        n = clamp_size(size_reg);
        if (mirror_count != 0)
        begin
            for (int unsigned e = mirror_count; e < n * n; e++)
                pending_elements.push_back(16'hFFFF);
            wait_idle();
        end

        // Out-of-range size acts as the full 64x64 store, so part of a
        // matrix loads with no result; the size then drops to 7 and the next
        // element completes it, window clamped to 7 over full-scale elements.
        reg_write(CFG_MATRIX_SIZE, 7'd127);
        reg_write(CFG_WINDOW_LENGTH, 7'd64);
        repeat (60) pending_elements.push_back(16'hFFFF);
        wait_idle();
        reg_write(CFG_MATRIX_SIZE, 7'd7);
        pending_elements.push_back(16'hFFFF);

        // -- Wrap up ---------------------------------------------------
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_best.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_best.size());
            error_count++;
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/twms_pkg.sv
rtl/core/twms_elem_if.sv
rtl/core/twms_result_if.sv
rtl/core/twms_scan_seq.sv
rtl/core/torus_window_max_sum.sv
tb/tb_torus_window_max_sum.sv
